// File: rtl/core/gdc_pkg.sv
// Shared widths, constants, stage handshake types and calendar tables for the date calculator.
`timescale 1ns / 1ps

package gdc_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int DOY_W  = 9;
  localparam int DNUM_W = 23;
  localparam int WD_W   = 3;
  localparam int DIFF_W = 22;

  // Divide by 25 as multiply by reciprocal: exact for operands below 2^15
  localparam int DIV25_S = 19;
  localparam int DIV25_W = 15;
  localparam logic [DIV25_W-1:0] DIV25_K = 15'd20972;
  localparam int Q25_W = 10;

  // Divide by 7 as multiply by reciprocal: exact for operands below 2^23
  localparam int DIV7_S = 26;
  localparam int DIV7_W = 24;
  localparam logic [DIV7_W-1:0] DIV7_K = 24'd9586981;
  localparam int Q7_W = DNUM_W + DIV7_W - DIV7_S;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // Day 0 of the count (1/1/0) fell on a Saturday
  localparam logic [DNUM_W-1:0] WD_OFFSET = 23'd6;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } gdc_adv_t;

  typedef struct packed {
    logic              valid;
    logic              leap;
    logic              last_dom;
    logic [DOY_W-1:0]  doy;
    logic [DNUM_W-1:0] dnum;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } gdc_date_t;

  // Days in the months before the given one, common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] month);
    logic [DOY_W-1:0] r;
    unique case (month)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month; zero for month codes outside the year
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/gregorian_date_calculator_unit.sv
// Gregorian date calculator: one date pair per cycle unless the output stalls.
// Five register stages, each with its own valid bit.
// A stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds every stage without loss.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
`timescale 1ns / 1ps

module gregorian_date_calculator_unit
  import gdc_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9],
  // end_day[27:23], end_month[31:28], end_year[45:32], zero fill [47:46]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_valid[0], end_valid[1], leap_year[2], day_of_year[11:3], weekday[14:12],
  // next_day[19:15], next_month[23:20], next_year[37:24], days_between[59:38],
  // zero fill [63:60]
  output logic [63:0] m_axis_tdata
);

  // Stage valid bits and load enables
  logic [4:0] vld;
  logic [4:0] rdy;
  gdc_adv_t   adv;

  assign rdy[4] = !vld[4] || m_axis_tready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];
  assign adv.s5 = rdy[4];

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[4];

  // Advance valid bits alongside the payload
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_axis_tvalid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
    end
  end

  gdc_date_t start_date;
  gdc_date_t end_date;

  gdc_date_conv #(
    .MAX_YEAR (MAX_YEAR)
  ) u_conv_start (
    .clk   (clk),
    .adv   (adv),
    .day   (s_axis_tdata[4:0]),
    .month (s_axis_tdata[8:5]),
    .year  (s_axis_tdata[22:9]),
    .date  (start_date)
  );

  gdc_date_conv #(
    .MAX_YEAR (MAX_YEAR)
  ) u_conv_end (
    .clk   (clk),
    .adv   (adv),
    .day   (s_axis_tdata[27:23]),
    .month (s_axis_tdata[31:28]),
    .year  (s_axis_tdata[45:32]),
    .date  (end_date)
  );

  logic              start_valid;
  logic              end_valid;
  logic              leap_year;
  logic [DOY_W-1:0]  day_of_year;
  logic [WD_W-1:0]   weekday;
  logic [DAY_W-1:0]  next_day;
  logic [MON_W-1:0]  next_month;
  logic [YEAR_W-1:0] next_year;
  logic [DIFF_W-1:0] days_between;

  gdc_finish u_finish (
    .clk          (clk),
    .adv          (adv),
    .start_date   (start_date),
    .end_date     (end_date),
    .start_valid  (start_valid),
    .end_valid    (end_valid),
    .leap_year    (leap_year),
    .day_of_year  (day_of_year),
    .weekday      (weekday),
    .next_day     (next_day),
    .next_month   (next_month),
    .next_year    (next_year),
    .days_between (days_between)
  );

  // Pack the result transfer
  assign m_axis_tdata = {4'b0000, days_between, next_year, next_month, next_day,
                         weekday, day_of_year, leap_year, end_valid, start_valid};

endmodule

// File: rtl/core/gdc_date_conv.sv
// Three-stage conversion of one date into validity, leap flag, day of year and day number.
`timescale 1ns / 1ps

module gdc_date_conv
  import gdc_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic              clk,
  input  gdc_adv_t          adv,
  input  logic [DAY_W-1:0]  day,
  input  logic [MON_W-1:0]  month,
  input  logic [YEAR_W-1:0] year,
  output gdc_date_t         date
);

  // Stage 1: range checks and reciprocal products
  logic [DAY_W-1:0]          day1;
  logic [MON_W-1:0]          month1;
  logic [YEAR_W-1:0]         year1;
  logic                      range_ok1;
  logic [YEAR_W+DIV25_W-1:0] prod_y1;
  logic [YEAR_W+DIV25_W-1:0] prod_c1;
  logic [YEAR_W+DIV25_W-1:0] prod_q1;
  logic [DNUM_W-1:0]         y365_1;

  logic [YEAR_W:0]   year_p99;
  logic [YEAR_W:0]   year_p399;
  logic [YEAR_W-1:0] cent_base;
  logic [YEAR_W-1:0] quad_base;

  assign year_p99  = {1'b0, year} + (YEAR_W+1)'(99);
  assign year_p399 = {1'b0, year} + (YEAR_W+1)'(399);
  assign cent_base = year_p99[YEAR_W:1] >> 1;
  assign quad_base = year_p399[YEAR_W:1] >> 3;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      day1      <= day;
      month1    <= month;
      year1     <= year;
      range_ok1 <= (month >= MON_JAN) && (month <= MON_DEC) && (32'(year) <= MAX_YEAR);
      prod_y1   <= (YEAR_W+DIV25_W)'(year) * (YEAR_W+DIV25_W)'(DIV25_K);
      prod_c1   <= (YEAR_W+DIV25_W)'(cent_base) * (YEAR_W+DIV25_W)'(DIV25_K);
      prod_q1   <= (YEAR_W+DIV25_W)'(quad_base) * (YEAR_W+DIV25_W)'(DIV25_K);
      y365_1    <= DNUM_W'(year) * DNUM_W'(365);
    end
  end

  // Stage 2: leap rule, month length, validity, ordinal and leap-day count
  function automatic logic [Q25_W-1:0] q25_slice(input logic [YEAR_W+DIV25_W-1:0] p);
    return p[DIV25_S +: Q25_W];
  endfunction

  logic [Q25_W-1:0]  q25;
  logic [Q25_W-1:0]  qc;
  logic [Q25_W-1:0]  qq;
  logic [YEAR_W:0]   q25_x25;
  logic              div25;
  logic              leap_c;
  logic [DAY_W-1:0]  mlen;
  logic [YEAR_W-1:0] leaps_c;
  logic [YEAR_W-1:0] year_p3;

  assign q25     = q25_slice(prod_y1);
  assign qc      = q25_slice(prod_c1);
  assign qq      = q25_slice(prod_q1);
  assign q25_x25 = ((YEAR_W+1)'(q25) << 4) + ((YEAR_W+1)'(q25) << 3) + (YEAR_W+1)'(q25);
  assign div25   = (q25_x25 == {1'b0, year1});
  assign leap_c  = (year1[1:0] == 2'b00) && (!div25 || (year1[3:0] == 4'b0000));
  assign mlen    = month_days(month1, leap_c);
  assign year_p3 = YEAR_W'(({1'b0, year1} + (YEAR_W+1)'(3)) >> 2);
  assign leaps_c = year_p3 - YEAR_W'(qc) + YEAR_W'(qq);

  logic              valid2;
  logic              leap2;
  logic              last2;
  logic [DOY_W-1:0]  doy2;
  logic [YEAR_W-1:0] leaps2;
  logic [DNUM_W-1:0] y365_2;
  logic [DAY_W-1:0]  day2;
  logic [MON_W-1:0]  month2;
  logic [YEAR_W-1:0] year2;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      valid2 <= range_ok1 && (day1 != '0) && (day1 <= mlen);
      leap2  <= leap_c;
      last2  <= (day1 == mlen);
      doy2   <= cum_days(month1) + DOY_W'(leap_c && (month1 > MON_FEB)) + DOY_W'(day1);
      leaps2 <= leaps_c;
      y365_2 <= y365_1;
      day2   <= day1;
      month2 <= month1;
      year2  <= year1;
    end
  end

  // Stage 3: day number counted from 1/1/0
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      date.valid    <= valid2;
      date.leap     <= leap2;
      date.last_dom <= last2;
      date.doy      <= doy2;
      date.dnum     <= y365_2 + DNUM_W'(leaps2) + DNUM_W'(doy2) - DNUM_W'(1);
      date.day      <= day2;
      date.month    <= month2;
      date.year     <= year2;
    end
  end

endmodule

// File: rtl/core/gdc_finish.sv
// Final two stages: weekday by reciprocal of seven, following date and day difference.
`timescale 1ns / 1ps

module gdc_finish
  import gdc_pkg::*;
(
  input  logic              clk,
  input  gdc_adv_t          adv,
  input  gdc_date_t         start_date,
  input  gdc_date_t         end_date,
  output logic              start_valid,
  output logic              end_valid,
  output logic              leap_year,
  output logic [DOY_W-1:0]  day_of_year,
  output logic [WD_W-1:0]   weekday,
  output logic [DAY_W-1:0]  next_day,
  output logic [MON_W-1:0]  next_month,
  output logic [YEAR_W-1:0] next_year,
  output logic [DIFF_W-1:0] days_between
);

  // Stage 4: weekday product, following date, difference
  logic [DNUM_W-1:0]        wd_x;
  logic [DNUM_W+DIV7_W-1:0] wd_prod4;
  logic [WD_W-1:0]          wd_low4;
  logic                     sv4;
  logic                     ev4;
  logic                     leap4;
  logic [DOY_W-1:0]         doy4;
  logic [DAY_W-1:0]         nd4;
  logic [MON_W-1:0]         nm4;
  logic [YEAR_W-1:0]        ny4;
  logic [DIFF_W-1:0]        diff4;

  logic [DAY_W-1:0]  nd_c;
  logic [MON_W-1:0]  nm_c;
  logic [YEAR_W-1:0] ny_c;

  assign wd_x = start_date.dnum + WD_OFFSET;

  // Roll over into the next month or year on the last day of a month
  always_comb begin
    nd_c = start_date.day + DAY_W'(1);
    nm_c = start_date.month;
    ny_c = start_date.year;
    if (start_date.last_dom) begin
      nd_c = DAY_W'(1);
      if (start_date.month == MON_DEC) begin
        nm_c = MON_JAN;
        ny_c = start_date.year + YEAR_W'(1);
      end else begin
        nm_c = start_date.month + MON_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      wd_prod4 <= (DNUM_W+DIV7_W)'(wd_x) * (DNUM_W+DIV7_W)'(DIV7_K);
      wd_low4  <= wd_x[WD_W-1:0];
      sv4      <= start_date.valid;
      ev4      <= end_date.valid;
      leap4    <= start_date.leap;
      doy4     <= start_date.doy;
      nd4      <= nd_c;
      nm4      <= nm_c;
      ny4      <= ny_c;
      if (start_date.valid && end_date.valid && (end_date.dnum > start_date.dnum)) begin
        diff4 <= DIFF_W'(end_date.dnum - start_date.dnum);
      end else begin
        diff4 <= '0;
      end
    end
  end

  // Stage 5: remainder mod 7 from the quotient, zero fields of an invalid start
  logic [Q7_W-1:0] q7;
  logic [WD_W-1:0] wd_c;

  assign q7   = wd_prod4[DIV7_S +: Q7_W];
  // x - 7q equals x + q - 8q; only the low bits survive
  assign wd_c = wd_low4 + q7[WD_W-1:0];

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      start_valid  <= sv4;
      end_valid    <= ev4;
      leap_year    <= sv4 && leap4;
      day_of_year  <= sv4 ? doy4 : '0;
      weekday      <= sv4 ? wd_c : '0;
      next_day     <= sv4 ? nd4 : '0;
      next_month   <= sv4 ? nm4 : '0;
      next_year    <= sv4 ? ny4 : '0;
      days_between <= diff4;
    end
  end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the Gregorian date calculator stream unit.
`timescale 1ns / 1ps

module tb_top
  import gdc_pkg::*;
();

  localparam int unsigned LAST_YEAR    = 9999;
  localparam int unsigned RANDOM_PAIRS = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned HOLD_CYCLES  = 60;

  // One date pair as it travels on the input bus, lowest field last
  typedef struct packed {
    logic [1:0]        pad;
    logic [YEAR_W-1:0] end_year;
    logic [MON_W-1:0]  end_month;
    logic [DAY_W-1:0]  end_day;
    logic [YEAR_W-1:0] start_year;
    logic [MON_W-1:0]  start_month;
    logic [DAY_W-1:0]  start_day;
  } date_pair_t;

  // One calendar result as it travels on the output bus
  typedef struct packed {
    logic [3:0]        pad;
    logic [DIFF_W-1:0] days_between;
    logic [YEAR_W-1:0] next_year;
    logic [MON_W-1:0]  next_month;
    logic [DAY_W-1:0]  next_day;
    logic [WD_W-1:0]   weekday;
    logic [DOY_W-1:0]  day_of_year;
    logic              leap_year;
    logic              end_valid;
    logic              start_valid;
  } date_info_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } cal_date_t;

  typedef struct {
    date_pair_t pair;
    bit         typed;
    date_info_t info;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  date_info_t  pending_info[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned sent_items;
  int unsigned burst_left;
  date_info_t  seen_info;
  date_info_t  want_info;

  gregorian_date_calculator_unit #(
    .MAX_YEAR(LAST_YEAR)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Calendar arithmetic for the prediction
  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_exists(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
    if (m < 1 || m > 12 || y > LAST_YEAR) return 1'b0;
    return d >= 1 && d <= month_length(m, y);
  endfunction

  function automatic int unsigned day_in_year(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
    int unsigned total;
    total = d;
    for (int unsigned i = 1; i < m; i++) total += month_length(i, y);
    return total;
  endfunction

  // Days since 1/1/0, leap days counted in closed form
  function automatic int unsigned day_count(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned leaps;
    leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    return y * 365 + leaps + day_in_year(d, m, y) - 1;
  endfunction

  function automatic date_info_t predict_date_info(input date_pair_t p);
    date_info_t  r;
    int unsigned sd, sm, sy, start_num, end_num;
    sd = p.start_day;
    sm = p.start_month;
    sy = p.start_year;
    r = '0;
    r.start_valid = date_exists(sd, sm, sy);
    r.end_valid   = date_exists(p.end_day, p.end_month, p.end_year);
    if (r.start_valid) begin
      start_num     = day_count(sd, sm, sy);
      r.leap_year   = is_leap_year(sy);
      r.day_of_year = DOY_W'(day_in_year(sd, sm, sy));
      r.weekday     = WD_W'((start_num + 6) % 7);
      // Roll over to the next month and, after December, the next year
      if (sd < month_length(sm, sy)) begin
        r.next_day   = DAY_W'(sd + 1);
        r.next_month = MON_W'(sm);
        r.next_year  = YEAR_W'(sy);
      end else if (sm == 12) begin
        r.next_day   = DAY_W'(1);
        r.next_month = MON_W'(1);
        r.next_year  = YEAR_W'(sy + 1);
      end else begin
        r.next_day   = DAY_W'(1);
        r.next_month = MON_W'(sm + 1);
        r.next_year  = YEAR_W'(sy);
      end
      if (r.end_valid) begin
        end_num = day_count(p.end_day, p.end_month, p.end_year);
        if (end_num > start_num) r.days_between = DIFF_W'(end_num - start_num);
      end
    end
    return r;
  endfunction

  function automatic date_pair_t pair_of(input int unsigned sd, input int unsigned sm,
                                         input int unsigned sy, input int unsigned ed,
                                         input int unsigned em, input int unsigned ey);
    date_pair_t p;
    p = '0;
    p.start_day   = DAY_W'(sd);
    p.start_month = MON_W'(sm);
    p.start_year  = YEAR_W'(sy);
    p.end_day     = DAY_W'(ed);
    p.end_month   = MON_W'(em);
    p.end_year    = YEAR_W'(ey);
    return p;
  endfunction

  function automatic date_info_t known_info(input bit sv, input bit ev, input bit leap,
                                            input int unsigned doy, input int unsigned wd,
                                            input int unsigned nd, input int unsigned nm,
                                            input int unsigned ny, input int unsigned diff);
    date_info_t r;
    r = '0;
    r.start_valid  = sv;
    r.end_valid    = ev;
    r.leap_year    = leap;
    r.day_of_year  = DOY_W'(doy);
    r.weekday      = WD_W'(wd);
    r.next_day     = DAY_W'(nd);
    r.next_month   = MON_W'(nm);
    r.next_year    = YEAR_W'(ny);
    r.days_between = DIFF_W'(diff);
    return r;
  endfunction

  // Mostly real dates, month ends weighted up, some raw field values
  function automatic cal_date_t random_date();
    cal_date_t   c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      c.day   = DAY_W'($urandom_range(0, 31));
      c.month = MON_W'($urandom_range(0, 15));
      c.year  = YEAR_W'($urandom_range(0, 16383));
    end else begin
      c.year  = YEAR_W'((pick == 3) ? $urandom_range(9990, 10010) : $urandom_range(0, 9999));
      c.month = MON_W'($urandom_range(1, 12));
      if (pick % 4 == 0) c.day = DAY_W'(month_length(c.month, c.year));
      else c.day = DAY_W'($urandom_range(1, month_length(c.month, c.year)));
    end
    return c;
  endfunction

  task automatic add_row(input date_pair_t p, input bit typed, input date_info_t info);
    stim_row_t row;
    row.pair  = p;
    row.typed = typed;
    row.info  = info;
    directed_rows.push_back(row);
  endtask

  // Offer one pair in bursts with random gaps; log the expectation on transfer
  task automatic offer_pair(input date_pair_t pair, input date_info_t info);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    do @(posedge clk); while (!s_axis_tready);
    pending_info.push_back(info);
    burst_left--;
    sent_items++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_info = m_axis_tdata;
      if (pending_info.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_info = pending_info.pop_front();
        check_field("start_valid", want_info.start_valid, seen_info.start_valid);
        check_field("end_valid", want_info.end_valid, seen_info.end_valid);
        check_field("leap_year", want_info.leap_year, seen_info.leap_year);
        check_field("day_of_year", want_info.day_of_year, seen_info.day_of_year);
        check_field("weekday", want_info.weekday, seen_info.weekday);
        check_field("next_day", want_info.next_day, seen_info.next_day);
        check_field("next_month", want_info.next_month, seen_info.next_month);
        check_field("next_year", want_info.next_year, seen_info.next_year);
        check_field("days_between", want_info.days_between, seen_info.days_between);
      end
    end
  end

  // Receiver: stall mode drawn at random from time to time, plus one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold_left;
    bit          hold_done;
    cyc       = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_items >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
          default: m_axis_tready <= (cyc % 3 == 0);
        endcase
      end
      cyc++;
    end
  end

  // Stimulus: reset, directed rows, random pairs, drain
  initial begin
    cal_date_t s_date;
    cal_date_t e_date;
    date_pair_t p;
    mismatches    = 0;
    sent_items    = 0;
    burst_left    = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Invalid start dates: only the end flag may be set
    add_row(pair_of(1, 0, 2000, 1, 1, 2000), 1'b1, known_info(0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(1, 13, 5, 1, 15, 5), 1'b1, known_info(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(0, 6, 2020, 31, 15, 16383), 1'b1,
            known_info(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(1, 1, 10000, 1, 1, 0), 1'b1, known_info(0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(29, 2, 1900, 1, 1, 1), 1'b1, known_info(0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(31, 4, 2021, 31, 4, 2021), 1'b1,
            known_info(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(pair_of(31, 15, 16383, 31, 2, 2024), 1'b1,
            known_info(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Extremes of the day count
    add_row(pair_of(1, 1, 0, 1, 1, 0), 1'b1, known_info(1, 1, 1, 1, 6, 2, 1, 0, 0));
    add_row(pair_of(1, 1, 0, 2, 1, 0), 1'b1, known_info(1, 1, 1, 1, 6, 2, 1, 0, 1));
    add_row(pair_of(1, 1, 0, 31, 12, 9999), 1'b1,
            known_info(1, 1, 1, 1, 6, 2, 1, 0, 3652424));
    add_row(pair_of(31, 12, 9999, 1, 1, 0), 1'b1,
            known_info(1, 1, 0, 365, 5, 1, 1, 10000, 0));
    // Leap rule, month ends, year end, end before start, invalid end
    add_row(pair_of(29, 2, 2000, 1, 3, 2000), 1'b0, '0);
    add_row(pair_of(29, 2, 2024, 29, 2, 2028), 1'b0, '0);
    add_row(pair_of(29, 2, 2023, 1, 3, 2023), 1'b0, '0);
    add_row(pair_of(28, 2, 2023, 1, 3, 2023), 1'b0, '0);
    add_row(pair_of(28, 2, 2024, 31, 12, 2024), 1'b0, '0);
    add_row(pair_of(30, 4, 1999, 1, 5, 1999), 1'b0, '0);
    add_row(pair_of(31, 12, 2023, 1, 1, 2024), 1'b0, '0);
    add_row(pair_of(15, 8, 2500, 14, 8, 2500), 1'b0, '0);
    add_row(pair_of(15, 8, 2500, 0, 8, 2600), 1'b0, '0);
    add_row(pair_of(31, 1, 400, 1, 13, 401), 1'b0, '0);
    add_row(pair_of(31, 12, 100, 31, 12, 10000), 1'b0, '0);

    foreach (directed_rows[i]) begin
      offer_pair(directed_rows[i].pair,
                 directed_rows[i].typed ? directed_rows[i].info
                                        : predict_date_info(directed_rows[i].pair));
    end

    // Random pairs; about one end date in three lies in its start's year, not before its month
    for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
      s_date = random_date();
      e_date = random_date();
      if ($urandom_range(0, 2) == 0 && s_date.month >= 1 && s_date.month <= 12) begin
        e_date       = s_date;
        e_date.day   = DAY_W'($urandom_range(1, 31));
        e_date.month = MON_W'($urandom_range(s_date.month, 12));
      end
      p = pair_of(s_date.day, s_date.month, s_date.year, e_date.day, e_date.month,
                  e_date.year);
      offer_pair(p, predict_date_info(p));
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (pending_info.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: gregorian_date_calculator_unit.f
rtl/core/gdc_pkg.sv
rtl/core/gdc_date_conv.sv
rtl/core/gdc_finish.sv
rtl/core/gregorian_date_calculator_unit.sv
test/tb_top.sv
